// ===== hw/rtl/gsd_pkg.sv =====
// Shared types, codes and divisor helper for the Golomb stream decoder.
// No dependencies; used by gsd_front, gsd_back and the top level.
package gsd_pkg;

  localparam int unsigned REM_WIDTH_DEFAULT = 16;
  localparam int unsigned QUO_WIDTH_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUES = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_OVERFLOW   = 2'd2
  } gsd_status_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_UNARY = 2'd1,
    PH_REM   = 2'd2,
    PH_HALT  = 2'd3
  } gsd_phase_e;

  // Divisor with everything the bit decoder needs, worked out at write time.
  typedef struct packed {
    logic [15:0] m;      // zero maps to one
    logic        pow2;   // signed Rice mode
    logic [4:0]  b;      // ceil(log2 m)
    logic [15:0] u;      // 2^b - m
    logic [4:0]  need;   // short remainder length
  } gsd_div_t;

  // Item from the bit decoder to the formatter.
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    gsd_status_e status;
    logic        stream_final;
  } gsd_job_t;

  // Item on the result queue.
  typedef struct packed {
    logic signed [32:0] value;
    gsd_status_e        status;
    logic               stream_final;
  } gsd_res_t;

  function automatic gsd_div_t gsd_derive(logic [15:0] raw);
    gsd_div_t    d;
    logic [15:0] m;
    logic [15:0] mm1;
    logic [4:0]  b;
    m   = (raw == 16'd0) ? 16'd1 : raw;
    mm1 = m - 16'd1;
    b   = 5'd0;
    // bit length of m-1
    for (int i = 0; i < 16; i++) begin
      if (mm1[i]) b = 5'(i + 1);
    end
    d.m    = m;
    d.pow2 = ((m & mm1) == 16'd0);
    d.b    = b;
    d.u    = 16'((17'd1 << b) - {1'b0, m});
    d.need = d.pow2 ? b : 5'(b - 5'd1);
    return d;
  endfunction

endpackage

// ===== hw/rtl/gsd_fifo.sv =====
// Small first-word-fall-through queue of flops.
// Generic; no package dependency.
module gsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with pointers apart");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> wr_ptr_q == rd_ptr_q)
    else $error("full queue with pointers apart");

endmodule

// ===== hw/rtl/gsd_front.sv =====
// Bit decoder: config registers, code state machine, running q*M product.
// Depends on gsd_pkg.
module gsd_front #(
  parameter int unsigned REMAINDER_WIDTH = 16,
  parameter int unsigned QUOTIENT_WIDTH  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gsd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             accept_i,
  input  logic                             code_bit_i,
  input  logic                             stream_end_i,
  output logic                             busy_o,
  output logic                             job_push_o,
  output gsd_pkg::gsd_job_t                job_o
);

  import gsd_pkg::*;

  localparam int unsigned RW = REMAINDER_WIDTH;
  localparam int unsigned QW = QUOTIENT_WIDTH;

  gsd_div_t          div_q;
  logic [15:0]       maxv_q;
  logic              recalc_q;

  gsd_phase_e        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [QW-1:0]     q_q, q_d;
  logic [RW-1:0]     acc_q, acc_d;
  logic [4:0]        rbits_q, rbits_d;
  logic [15:0]       vd_q, vd_d;
  logic [32:0]       base_q, base_d;  // q*M, bit 32 sticky once it reaches 2^32

  logic [QW+15:0]    prod;
  logic [47:0]       prod_wide;
  logic [32:0]       prod_sat;
  logic [32:0]       base_inc;
  logic [RW-1:0]     acc_new;
  logic [4:0]        rbits_new;
  logic [31:0]       r32, u32, r_adj, r_use;
  logic              rem_done;
  logic [33:0]       sum;
  logic              ovf;
  logic [15:0]       vd_inc;
  logic              emit, val_path, fin, stream_fin;
  gsd_status_e       status;

  // Config registers; a divisor write re-derives q*M on the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= gsd_derive(16'd4);
      maxv_q   <= '0;
      recalc_q <= 1'b0;
    end else begin
      recalc_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIVISOR: begin
            div_q    <= gsd_derive(cfg_wdata_i);
            recalc_q <= 1'b1;
          end
          CFG_MAX_VALUES: maxv_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign busy_o = recalc_q;

  assign prod      = q_q * div_q.m;
  assign prod_wide = 48'(prod);
  assign prod_sat  = (|prod_wide[47:32]) ? {1'b1, 32'd0} : {1'b0, prod_wide[31:0]};
  assign base_inc  = base_q[32] ? base_q : base_q + 33'(div_q.m);

  assign acc_new   = RW'({acc_q, code_bit_i});
  assign rbits_new = rbits_q + 5'(rbits_q != 5'd31);
  assign r32       = 32'(acc_new);
  assign u32       = 32'(div_q.u);

  // Pow2: b bits. Truncated binary: short ends once r < u, long after b bits.
  always_comb begin
    if (div_q.pow2) begin
      rem_done = (rbits_new >= div_q.need);
      r_adj    = r32;
    end else if (rbits_new >= div_q.b) begin
      rem_done = 1'b1;
      r_adj    = (r32 >= u32) ? r32 - u32 : r32;
    end else begin
      rem_done = (rbits_new >= div_q.need) && (r32 < u32);
      r_adj    = r32;
    end
  end

  assign r_use  = (phase_q == PH_REM) ? r_adj : 32'd0;
  assign sum    = 34'(base_q) + 34'(r_use);
  assign ovf    = |sum[33:32];
  assign vd_inc = vd_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    q_d      = q_q;
    acc_d    = acc_q;
    rbits_d  = rbits_q;
    vd_d     = vd_q;
    base_d   = base_q;
    emit     = 1'b0;
    val_path = 1'b0;
    fin      = 1'b0;
    status   = ST_OK;

    if (recalc_q) begin
      base_d = prod_sat;
    end else if (accept_i) begin
      unique case (phase_q) inside
        PH_HALT: begin
          if (stream_end_i) begin
            phase_d = PH_START;
            vd_d    = '0;
          end
        end
        PH_START, PH_UNARY: begin
          if (phase_q == PH_START && div_q.pow2) begin
            neg_d   = code_bit_i;
            phase_d = PH_UNARY;
            if (stream_end_i) begin
              emit   = 1'b1;
              status = ST_INCOMPLETE;
            end
          end else if (code_bit_i) begin
            if (&q_q) begin
              emit   = 1'b1;
              status = ST_OVERFLOW;
            end else begin
              q_d     = q_q + 1'b1;
              base_d  = base_inc;
              phase_d = PH_UNARY;
              if (stream_end_i) begin
                emit   = 1'b1;
                status = ST_INCOMPLETE;
              end
            end
          end else begin
            phase_d = PH_REM;
            acc_d   = '0;
            rbits_d = '0;
            if (div_q.need == 5'd0) begin
              val_path = 1'b1;
            end else if (stream_end_i) begin
              emit   = 1'b1;
              status = ST_INCOMPLETE;
            end
          end
        end
        PH_REM: begin
          acc_d   = acc_new;
          rbits_d = rbits_new;
          if (rem_done) begin
            val_path = 1'b1;
          end else if (stream_end_i) begin
            emit   = 1'b1;
            status = ST_INCOMPLETE;
          end
        end
        default: ;
      endcase

      if (val_path) begin
        emit = 1'b1;
        if (ovf) begin
          status = ST_OVERFLOW;
        end else begin
          vd_d = vd_inc;
          fin  = stream_end_i || (maxv_q != 16'd0 && vd_inc == maxv_q);
        end
      end
    end

    stream_fin = (status != ST_OK) || fin;

    if (emit) begin
      neg_d   = 1'b0;
      q_d     = '0;
      acc_d   = '0;
      rbits_d = '0;
      base_d  = '0;
      if (stream_fin && !stream_end_i) begin
        phase_d = PH_HALT;
      end else begin
        phase_d = PH_START;
        if (stream_end_i) vd_d = '0;
      end
    end

    job_push_o          = emit;
    job_o.neg           = neg_q;
    job_o.mag           = sum[31:0];
    job_o.status        = status;
    job_o.stream_final  = stream_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      q_q     <= '0;
      acc_q   <= '0;
      rbits_q <= '0;
      vd_q    <= '0;
      base_q  <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      q_q     <= q_d;
      acc_q   <= acc_d;
      rbits_q <= rbits_d;
      vd_q    <= vd_d;
      base_q  <= base_d;
    end
  end

  a_halt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> q_q == '0 && rbits_q == '0 && base_q == '0)
    else $error("halted with code state left");

  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o && job_o.status != ST_OK |-> job_o.stream_final)
    else $error("error item does not close the stream");

  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && stream_end_i |=> phase_q == PH_START && vd_q == '0)
    else $error("stream end did not restart decoding");

endmodule

// ===== hw/rtl/gsd_back.sv =====
// Result formatter: signs the magnitude, zeroes error items, feeds result queue.
// Depends on gsd_pkg.
module gsd_back (
  input  logic              job_empty_i,
  input  gsd_pkg::gsd_job_t job_i,
  output logic              job_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output gsd_pkg::gsd_res_t res_o
);

  import gsd_pkg::*;

  logic [32:0] mag33;

  assign job_pop_o  = !job_empty_i && !res_full_i;
  assign res_push_o = job_pop_o;
  assign mag33      = {1'b0, job_i.mag};

  always_comb begin
    res_o.status       = job_i.status;
    res_o.stream_final = job_i.stream_final;
    unique case (job_i.status)
      ST_OK:   res_o.value = job_i.neg ? -$signed(mag33) : $signed(mag33);
      default: res_o.value = '0;
    endcase
  end

endmodule

// ===== hw/rtl/golomb_stream_decoder_core.sv =====
// Golomb / Rice serial bitstream decoder, top level.
// Depends on gsd_pkg, gsd_front, gsd_fifo and gsd_back.
//
// Input channel: one coded bit per item (code_bit_i, stream_end_i), taken
// at an edge with push high and full low. Result channel: the oldest result
// sits on decoded_value_o / status_o / stream_final_o while empty is low and
// leaves at an edge with pop high. A result is registered in the job queue and then
// in the result queue after the bit that completes a code (or ends the stream in
// error) is taken; bits that complete nothing give no result.
// Throughput is one bit per cycle while full is low: the bit decoder
// updates its state for each bit taken and keeps q*M as a running sum.
// Writing the divisor holds full high for the following cycle while q*M
// is rebuilt with one multiply. A two-entry queue sits between the decoder
// and the formatter and another in front of the result ports, so a stalled
// receiver only backs up into full once both queues are full.
// Configuration: cfg_we_i with cfg_idx_i 0 (divisor) or 1 (max_values),
// written while the block is idle. Reset gives divisor 4, max_values 0,
// empty queues and a decoder waiting for the first bit of a code.
module golomb_stream_decoder_core #(
  parameter int unsigned REMAINDER_WIDTH = gsd_pkg::REM_WIDTH_DEFAULT,
  parameter int unsigned QUOTIENT_WIDTH  = gsd_pkg::QUO_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           code_bit_i,
  input  logic                           stream_end_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [32:0]             decoded_value_o,
  output logic [1:0]                     status_o,
  output logic                           stream_final_o
);

  import gsd_pkg::*;

  logic     accept;
  logic     busy;
  logic     job_push, job_full, job_pop, job_empty;
  gsd_job_t job_in, job_out;
  logic     res_push, res_full;
  gsd_res_t res_in, res_out;

  assign full   = job_full || busy;
  assign accept = push && !full;

  gsd_front #(
    .REMAINDER_WIDTH (REMAINDER_WIDTH),
    .QUOTIENT_WIDTH  (QUOTIENT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .code_bit_i   (code_bit_i),
    .stream_end_i (stream_end_i),
    .busy_o       (busy),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  gsd_fifo #(
    .WIDTH ($bits(gsd_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  gsd_back u_back (
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  gsd_fifo #(
    .WIDTH ($bits(gsd_res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign decoded_value_o = res_out.value;
  assign status_o        = res_out.status;
  assign stream_final_o  = res_out.stream_final;

endmodule
